// File: rtl/b64u_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64u_pkg: shared types and helpers for the base64url stream decoder
// Beat payload structs, the per-character sextet lookup and group descriptor.
// ----------------------------------------------------------------------------
package b64u_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned SextetW  = 7;   // 0..63 data, plus pad and bad codes
  localparam int unsigned AccumW   = 18;  // three sextets
  localparam int unsigned TripleW  = 24;  // four sextets, three bytes
  localparam int unsigned CountW   = 2;   // bytes per group, 0..3

  localparam logic [SextetW-1:0] SextetPad  = 7'd64;
  localparam logic [SextetW-1:0] SextetBad  = 7'd65;
  localparam logic [SextetW-1:0] SextetDash = 7'd62;
  localparam logic [SextetW-1:0] SextetUscr = 7'd63;
  localparam logic [SextetW-1:0] LowerBase  = 7'd26;
  localparam logic [SextetW-1:0] DigitBase  = 7'd52;

  // Input beat: one character and the end-of-text flag
  typedef struct packed {
    logic [CharW-1:0] text_char;
    logic             is_final;
  } in_t;

  // Output beat: one decoded byte or an end marker
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_output;
    logic       failed;
  } out_t;

  // Group handed from the decoder to the serializer
  typedef struct packed {
    logic [TripleW-1:0] triple;
    logic [CountW-1:0]  nbytes;
    logic               fin;
    logic               failed;
  } grp_t;

  // Map a character to its sextet value, the pad code or the bad code
  function automatic logic [SextetW-1:0] sextet_of(input logic [CharW-1:0] c);
    logic [SextetW-1:0] v;
    v = SextetBad;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = SextetW'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = SextetW'(c - 8'h61) + LowerBase;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = SextetW'(c - 8'h30) + DigitBase;
    end else if (c == 8'h2D || c == 8'h2B) begin
      v = SextetDash;
    end else if (c == 8'h5F || c == 8'h2F) begin
      v = SextetUscr;
    end else if (c == 8'h3D) begin
      v = SextetPad;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/b64u_dec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64u_dec: character decoder and group state
// Folds each accepted character into the current group and reports a finished
// group (bytes, end marker, failure) in the same cycle.
// ----------------------------------------------------------------------------
module b64u_dec
  import b64u_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic accept_i,
  input  wire in_t  char_i,
  output logic      grp_need_o,
  output logic      grp_valid_o,
  output grp_t      grp_o
);

  logic [1:0]        slot_q, slot_d;
  logic [AccumW-1:0] sext_q, sext_d;
  logic              pad_q, pad_d;
  logic              err_q, err_d;

  // Decode one character against the group state
  always_comb begin
    logic [SextetW-1:0] v;
    logic [TripleW-1:0] triple;
    logic [CountW-1:0]  nb;
    logic [29:0]        wide;
    v      = sextet_of(char_i.text_char);
    triple = '0;
    nb     = '0;
    wide   = '0;
    slot_d = slot_q;
    sext_d = sext_q;
    pad_d  = pad_q;
    err_d  = err_q;

    if (!err_q) begin
      if (v == SextetBad) begin
        err_d = 1'b1;
      end else if (v == SextetPad) begin
        if (slot_q < 2'd2) begin
          err_d = 1'b1;
        end else if (slot_q == 2'd2) begin
          pad_d  = 1'b1;
          sext_d = {sext_q[AccumW-7:0], 6'd0};
          slot_d = 2'd3;
        end else begin
          triple = {sext_q, 6'd0};
          nb     = pad_q ? 2'd1 : 2'd2;
          slot_d = '0;
          sext_d = '0;
          pad_d  = 1'b0;
        end
      end else begin
        if (pad_q) begin
          err_d = 1'b1;
        end else if (slot_q == 2'd3) begin
          triple = {sext_q, v[5:0]};
          nb     = 2'd3;
          slot_d = '0;
          sext_d = '0;
          pad_d  = 1'b0;
        end else begin
          sext_d = {sext_q[AccumW-7:0], v[5:0]};
          slot_d = slot_q + 2'd1;
        end
      end
    end

    // Imply the missing padding at end of text
    if (char_i.is_final && !err_d) begin
      if (slot_d == 2'd1) begin
        err_d = 1'b1;
      end else if (slot_d >= 2'd2) begin
        if (slot_d == 2'd2) begin
          wide = {sext_d, 12'd0};
        end else begin
          wide = {6'd0, sext_d, 6'd0};
        end
        triple = wide[TripleW-1:0];
        nb     = pad_d ? 2'd1 : (slot_d - 2'd1);
      end
    end

    if (err_d) begin
      nb = '0;
    end

    grp_o.triple = triple;
    grp_o.nbytes = nb;
    grp_o.fin    = char_i.is_final;
    grp_o.failed = err_d;
    grp_need_o   = (nb != '0) || char_i.is_final;

    // Return to reset state after the end of text
    if (char_i.is_final) begin
      slot_d = '0;
      sext_d = '0;
      pad_d  = 1'b0;
      err_d  = 1'b0;
    end
  end

  // Hand a group to the serializer only on an accepted beat
  assign grp_valid_o = accept_i && grp_need_o;

  // Advance group state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      sext_q <= '0;
      pad_q  <= 1'b0;
      err_q  <= 1'b0;
    end else if (accept_i) begin
      slot_q <= slot_d;
      sext_q <= sext_d;
      pad_q  <= pad_d;
      err_q  <= err_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/b64u_ser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64u_ser: group serializer and output register
// Holds one finished group and hands its bytes out one beat per cycle unless stalled.
// ----------------------------------------------------------------------------
module b64u_ser
  import b64u_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic grp_valid_i,
  input  wire grp_t grp_i,
  output logic      ready_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  logic               cur_vld_q, cur_vld_d;
  grp_t               cur_q, cur_d;
  logic               out_vld_q, out_vld_d;
  out_t               out_q, out_d;
  logic               out_free;
  logic               last;
  logic               move;
  logic               done;
  out_t               item;

  // Form the next beat from the held group
  always_comb begin
    out_free = !out_vld_q || !out_stall_i;
    last     = (cur_q.nbytes <= 2'd1);
    move     = cur_vld_q && out_free;
    done     = move && last;
    ready_o  = !cur_vld_q || done;

    item.byte_valid    = (cur_q.nbytes != '0);
    item.data_byte     = item.byte_valid ? cur_q.triple[TripleW-1 -: 8] : 8'd0;
    item.end_of_output = last && cur_q.fin;
    item.failed        = last && cur_q.fin && cur_q.failed;
  end

  // Load, shift or drop the held group
  always_comb begin
    cur_vld_d = cur_vld_q;
    cur_d     = cur_q;
    if (grp_valid_i && ready_o) begin
      cur_vld_d = 1'b1;
      cur_d     = grp_i;
    end else if (done) begin
      cur_vld_d = 1'b0;
    end else if (move) begin
      cur_d.triple = {cur_q.triple[TripleW-9:0], 8'd0};
      cur_d.nbytes = cur_q.nbytes - 2'd1;
    end

    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (move) begin
      out_vld_d = 1'b1;
      out_d     = item;
    end else if (out_free) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cur_vld_q <= cur_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// File: rtl/base64url_stream_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// base64url_stream_decoder_unit: streaming base64 / base64url decoder
// A group's first byte passes the held-group and output registers after its
// last character is accepted; the rest follow one per cycle unless stalled.
// Throughput: one character per cycle; only a character that closes a group or
// the text waits, while the serializer still holds the previous group's bytes.
// Reset clears group state, the sticky error flag and all valid flags.
// ----------------------------------------------------------------------------
module base64url_stream_decoder_unit
  import b64u_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  logic accept;
  logic ser_ready;
  logic grp_need;
  logic grp_valid;
  grp_t grp;

  // Hold a character only when its group cannot enter the serializer
  assign in_stall_o = grp_need && !ser_ready;
  assign accept     = in_valid_i && !in_stall_o;

  b64u_dec u_dec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .char_i     (in_data_i),
    .grp_need_o (grp_need),
    .grp_valid_o(grp_valid),
    .grp_o      (grp)
  );

  b64u_ser u_ser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .grp_valid_i(grp_valid),
    .grp_i      (grp),
    .ready_o    (ser_ready),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for base64url_stream_decoder_unit
// Streams base64 and base64url texts, some well formed and some broken, under
// several idle and stall mixes, and checks every output beat against a local
// model of the decoder. A short directed table opens the run.
// ----------------------------------------------------------------------------
module testbench;
  import b64u_pkg::*;

  localparam logic [7:0] CharPad = "=";

  // Result beats written out by hand in the directed table
  localparam out_t EndFailed = {8'h00, 1'b0, 1'b1, 1'b1};
  localparam out_t ByteFf    = {8'hFF, 1'b1, 1'b0, 1'b0};
  localparam out_t ByteFfEnd = {8'hFF, 1'b1, 1'b1, 1'b0};
  localparam out_t Byte00End = {8'h00, 1'b1, 1'b1, 1'b0};
  localparam out_t NoBeat    = '0;

  typedef enum int {GrpFull, GrpOnePad, GrpTwoPad, GrpOpen3, GrpOpen2} group_shape_e;
  typedef enum int {NoiseByte, NoisePad, NoiseDrop, NoiseExtra, NoiseJunk} noise_e;

  // One character beat, optionally with its results typed in
  typedef struct packed {
    in_t          beat;
    logic         typed;
    logic [1:0]   n_typed;
    out_t [2:0]   typed_res;
  } char_rec_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  // Local copy of the decoder state
  logic [1:0]  grp_pos;
  logic [17:0] grp_bits;
  logic        grp_padded;
  logic        err_flag;

  char_rec_t   directed_rows[$];
  char_rec_t   pending_chars[$];
  out_t        expected_bytes[$];
  logic [7:0]  text_buf[$];

  int unsigned mismatches;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int          hold_off_cycles;

  base64url_stream_decoder_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Classify a character: sextet value, pad or bad
  function automatic logic [6:0] char_code(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return 7'(c - "A");
    if (c >= "a" && c <= "z") return 7'(c - "a") + LowerBase;
    if (c >= "0" && c <= "9") return 7'(c - "0") + DigitBase;
    if (c == "-" || c == "+") return SextetDash;
    if (c == "_" || c == "/") return SextetUscr;
    if (c == CharPad) return SextetPad;
    return SextetBad;
  endfunction

  // Pick a character for a sextet from either alphabet
  function automatic logic [7:0] sextet_char(input logic [5:0] v, input bit std_alpha);
    if (v < LowerBase) return "A" + 8'(v);
    if (v < DigitBase) return "a" + 8'(v - LowerBase);
    if (v < SextetDash) return "0" + 8'(v - DigitBase);
    if (v == SextetDash) return std_alpha ? "+" : "-";
    return std_alpha ? "/" : "_";
  endfunction

  // Advance the local decoder by one character; queue its result beats
  task automatic decode_char(input in_t beat, input bit emit);
    logic [6:0]  code;
    logic [23:0] word;
    int          nbytes;
    out_t        res [0:2];
    int          n;
    word = '0;
    nbytes = 0;
    n = 0;
    if (!err_flag) begin
      code = char_code(beat.text_char);
      if (code == SextetBad) begin
        err_flag = 1'b1;
      end else if (code == SextetPad) begin
        if (grp_pos < 2) begin
          err_flag = 1'b1;
        end else if (grp_pos == 2) begin
          grp_padded = 1'b1;
          grp_bits = {grp_bits[11:0], 6'd0};
          grp_pos = 2'd3;
        end else begin
          word = {grp_bits, 6'd0};
          nbytes = grp_padded ? 1 : 2;
          grp_pos = '0;
          grp_bits = '0;
          grp_padded = 1'b0;
        end
      end else if (grp_padded) begin
        err_flag = 1'b1;
      end else if (grp_pos == 3) begin
        word = {grp_bits, code[5:0]};
        nbytes = 3;
        grp_pos = '0;
        grp_bits = '0;
        grp_padded = 1'b0;
      end else begin
        grp_bits = {grp_bits[11:0], code[5:0]};
        grp_pos = grp_pos + 2'd1;
      end
    end
    // Imply missing padding on the last character
    if (beat.is_final && !err_flag) begin
      if (grp_pos == 1) begin
        err_flag = 1'b1;
      end else if (grp_pos >= 2) begin
        word = {6'd0, grp_bits} << (6 * (4 - grp_pos));
        nbytes = (grp_padded ? 2 : grp_pos) - 1;
      end
    end
    if (err_flag) nbytes = 0;
    for (int k = 0; k < nbytes; k++) begin
      res[n] = '0;
      res[n].data_byte = 8'(word >> (16 - 8 * k));
      res[n].byte_valid = 1'b1;
      n++;
    end
    // Close the text: mark the last beat and start over
    if (beat.is_final) begin
      if (n == 0) begin
        res[0] = '0;
        n = 1;
      end
      res[n-1].end_of_output = 1'b1;
      res[n-1].failed = err_flag;
      grp_pos = '0;
      grp_bits = '0;
      grp_padded = 1'b0;
      err_flag = 1'b0;
    end else begin
      n = (nbytes == 0) ? 0 : n;
    end
    if (emit) begin
      for (int k = 0; k < n; k++) expected_bytes.push_back(res[k]);
    end
  endtask

  task automatic add_text(input string s, input bit fin_last);
    char_rec_t r;
    for (int i = 0; i < s.len(); i++) begin
      r = '0;
      r.beat.text_char = s[i];
      r.beat.is_final = fin_last && (i == s.len() - 1);
      directed_rows.push_back(r);
    end
  endtask

  task automatic add_typed(input logic [7:0] c, input bit fin, input logic [1:0] n,
                           input out_t r0, input out_t r1, input out_t r2);
    char_rec_t r;
    r = '0;
    r.beat.text_char = c;
    r.beat.is_final = fin;
    r.typed = 1'b1;
    r.n_typed = n;
    r.typed_res = {r2, r1, r0};
    directed_rows.push_back(r);
  endtask

  // Offer one character, idling first at random; return at its accepting edge
  task automatic send_char(input char_rec_t rec);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    pending_chars.push_back(rec);
    in_valid_i <= 1'b1;
    in_data_i <= rec.beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Hold the input until every expected beat has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Build a random text of one to three groups, sometimes broken
  task automatic compose_text(input bit allow_noise);
    group_shape_e shape;
    int           n_groups;
    int           n_data;
    int           n_pads;
    int           pos;
    noise_e       noise;
    text_buf.delete();
    n_groups = $urandom_range(1, 3);
    for (int g = 0; g < n_groups; g++) begin
      if (g == n_groups - 1) shape = group_shape_e'($urandom_range(GrpFull, GrpOpen2));
      else shape = group_shape_e'($urandom_range(GrpFull, GrpTwoPad));
      case (shape)
        GrpFull:   begin n_data = 4; n_pads = 0; end
        GrpOnePad: begin n_data = 3; n_pads = 1; end
        GrpTwoPad: begin n_data = 2; n_pads = 2; end
        GrpOpen3:  begin n_data = 3; n_pads = 0; end
        default:   begin n_data = 2; n_pads = 0; end
      endcase
      repeat (n_data) begin
        text_buf.push_back(sextet_char(6'($urandom_range(0, 63)),
                                       1'($urandom_range(0, 1))));
      end
      repeat (n_pads) text_buf.push_back(CharPad);
    end
    if (allow_noise && $urandom_range(99) < 30) begin
      pos = $urandom_range(0, text_buf.size() - 1);
      noise = noise_e'($urandom_range(NoiseByte, NoiseJunk));
      case (noise)
        NoiseByte: text_buf[pos] = 8'($urandom_range(0, 255));
        NoisePad:  text_buf[pos] = CharPad;
        NoiseDrop: if (text_buf.size() > 1) void'(text_buf.pop_back());
        NoiseExtra: text_buf.push_back(sextet_char(6'($urandom_range(0, 63)), 1'b0));
        default: begin
          text_buf.delete();
          repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  // Stream random texts under one idle and stall mix, then drain
  task automatic run_texts(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int n_chars, input int hold, input bit allow_noise);
    char_rec_t rec;
    int        sent;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    hold_off_cycles = hold;
    sent = 0;
    while (sent < n_chars) begin
      compose_text(allow_noise);
      foreach (text_buf[i]) begin
        rec = '0;
        rec.beat.text_char = text_buf[i];
        rec.beat.is_final = (i == text_buf.size() - 1);
        send_char(rec);
      end
      sent += text_buf.size();
    end
    drain_results();
  endtask

  // Drive the output stall: random, or held high for a counted stretch
  initial begin : receiver
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles > 0) begin
        hold_off_cycles = hold_off_cycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Predict on each accepted character, check each accepted result
  always @(posedge clk_i) begin : monitor
    char_rec_t rec;
    out_t      got;
    out_t      want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        rec = pending_chars.pop_front();
        decode_char(in_data_i, !rec.typed);
        if (rec.typed) begin
          for (int k = 0; k < rec.n_typed; k++) expected_bytes.push_back(rec.typed_res[k]);
        end
      end
      if (out_valid_o && !out_stall_i) begin
        got = out_data_o;
        if (expected_bytes.size() == 0) begin
          mismatches++;
          $display({"%0t: result mismatch: expected no result,",
                    " got byte=%02h valid=%b end=%b failed=%b"},
                   $time, got.data_byte, got.byte_valid, got.end_of_output, got.failed);
        end else begin
          want = expected_bytes.pop_front();
          if (got.data_byte !== want.data_byte || got.byte_valid !== want.byte_valid ||
              got.end_of_output !== want.end_of_output || got.failed !== want.failed) begin
            mismatches++;
            $display({"%0t: result mismatch: expected byte=%02h valid=%b end=%b failed=%b,",
                      " got byte=%02h valid=%b end=%b failed=%b"}, $time,
                     want.data_byte, want.byte_valid, want.end_of_output, want.failed,
                     got.data_byte, got.byte_valid, got.end_of_output, got.failed);
          end
        end
      end
    end
  end

  initial begin : main
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    grp_pos = '0;
    grp_bits = '0;
    grp_padded = 1'b0;
    err_flag = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;

    // Directed texts: extremes, both alphabets, pad groups, every error
    add_text("///", 1'b0);
    add_typed("/", 1'b1, 2'd3, ByteFf, ByteFf, ByteFfEnd);
    add_text("+-9=_z==A", 1'b0);
    add_typed("A", 1'b1, 2'd1, Byte00End, NoBeat, NoBeat);
    add_text("QUI", 1'b1);
    add_typed("A", 1'b1, 2'd1, EndFailed, NoBeat, NoBeat);
    add_text("A", 1'b0);
    add_typed(CharPad, 1'b1, 2'd1, EndFailed, NoBeat, NoBeat);
    add_text("AB=C", 1'b0);
    add_typed(8'h00, 1'b0, 2'd0, NoBeat, NoBeat, NoBeat);
    add_typed(8'hFF, 1'b1, 2'd1, EndFailed, NoBeat, NoBeat);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_char(directed_rows[i]);
    drain_results();

    // Random texts under each idle and stall mix
    run_texts(0, 0, 14, 0, 1'b1);
    run_texts(45, 0, 14, 0, 1'b1);
    run_texts(0, 45, 14, 0, 1'b1);
    run_texts(30, 30, 14, 0, 1'b1);
    // Back up the output with a long hold-off while clean texts keep coming
    run_texts(0, 0, 12, 40, 1'b0);

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("base64url_stream_decoder_unit regression: pass");
    end else begin
      $display("base64url_stream_decoder_unit regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("base64url_stream_decoder_unit regression: fail");
    $finish;
  end

endmodule
